/* src/set_assoc_lru_cache_sim_defines.svh */
// ------------------------------------------------------------------------
// Set-associative LRU cache simulator: assertion macros
// Shared assertion forms for the cache block, clocked on clk and
// quiet while rst_n is low.
// ------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define SALC_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define SALC_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* src/salc_pkg.sv */
// ------------------------------------------------------------------------
// Set-associative LRU cache simulator: package
// Outcome codes, register map and the access status word shared by the
// cache modules.
// ------------------------------------------------------------------------
package salc_pkg;

    // Outcome of one cache access.
    typedef enum logic [1:0] {
        OUTCOME_HIT   = 2'd0,
        OUTCOME_FILL  = 2'd1,
        OUTCOME_EVICT = 2'd2
    } outcome_t;

    // Status of one resolved access, passed from the way logic to the top.
    typedef struct packed {
        outcome_t outcome;
        logic     hit;
        logic     miss;
        logic     evict;
    } access_status_t;

    // Register port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_WAYS_USED   = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    // Register field widths.
    localparam int SET_BITS_W    = 4;
    localparam int WAYS_USED_W   = 4;
    localparam int OFFSET_BITS_W = 5;

    // Width of the combined shift amount for the tag.
    localparam int SHIFT_W = 6;

endpackage

/* src/set_assoc_lru_cache_sim.sv */
// ------------------------------------------------------------------------
// Set-associative LRU cache simulator: top level
// Splits each address into set and tag, resolves the access against the
// set memory and reports hit, fill or eviction with saturating totals.
// ------------------------------------------------------------------------
// A single access reads its set row into the set memory's read register,
// then resolves the row and writes it back, loading the result word; a
// modify item makes a second access on the row just written, which is
// held in a register. The set memory has a single write port. Resolving
// waits while a stalled result word is held. A new item is taken while a
// result word still waits in the output register. Reset needs no clearing
// pass: a flop per set row marks rows never written, and they read as empty.
module set_assoc_lru_cache_sim
    import salc_pkg::*;
#(
    parameter int SET_BITS_MAX = 8,
    parameter int WAYS         = 8,
    parameter int ADDR_BITS    = 48,
    parameter int COUNT_BITS   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    // Input words
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ADDR_BITS-1:0]  address,
    input  logic                  mode,
    // Result words
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            outcome,
    output logic                  last,
    output logic [COUNT_BITS-1:0] hits_total,
    output logic [COUNT_BITS-1:0] misses_total,
    output logic [COUNT_BITS-1:0] evictions_total
);

`include "set_assoc_lru_cache_sim_defines.svh"

    localparam int NSETS  = 1 << SET_BITS_MAX;
    localparam int SET_W  = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W   = $clog2(WAYS + 1);
    localparam int ROW_W  = WAYS * (1 + RANK_W + ADDR_BITS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_SECOND
    } state_t;

    state_t                  state_reg, state_next;
    logic [SET_BITS_W-1:0]   set_bits_reg, set_bits_next;
    logic [WAYS_USED_W-1:0]  ways_used_reg, ways_used_next;
    logic [OFFSET_BITS_W-1:0] offset_bits_reg, offset_bits_next;
    logic [SET_W-1:0]        set_reg, set_next;
    logic [ADDR_BITS-1:0]    tag_reg, tag_next;
    logic                    mode_reg, mode_next;
    logic [ROW_W-1:0]        fwd_row_reg, fwd_row_next;
    logic [COUNT_BITS-1:0]   hits_reg, hits_next;
    logic [COUNT_BITS-1:0]   misses_reg, misses_next;
    logic [COUNT_BITS-1:0]   evicts_reg, evicts_next;
    logic                    out_valid_reg, out_valid_next;
    outcome_t                outcome_reg, outcome_next;
    logic                    last_reg, last_next;
    logic [COUNT_BITS-1:0]   hits_out_reg, hits_out_next;
    logic [COUNT_BITS-1:0]   misses_out_reg, misses_out_next;
    logic [COUNT_BITS-1:0]   evicts_out_reg, evicts_out_next;

    logic                    cfg_write;
    logic                    in_accept;
    logic                    res_fire;
    logic [SET_BITS_W-1:0]   sb_eff;
    logic [NW_W-1:0]         nways;
    logic [ADDR_BITS-1:0]    addr_shifted;
    logic [SET_W-1:0]        set_mask;
    logic [SET_W-1:0]        set_idx;
    logic [SHIFT_W-1:0]      tag_shift;
    logic [ROW_W-1:0]        mem_rd_data;
    logic [ROW_W-1:0]        row_cur;
    logic [ROW_W-1:0]        row_new;
    access_status_t          status;

    // Register port: always ready, written in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SET_BITS:    prdata = PDATA_W'(set_bits_reg);
            REG_WAYS_USED:   prdata = PDATA_W'(ways_used_reg);
            REG_OFFSET_BITS: prdata = PDATA_W'(offset_bits_reg);
            default:         prdata = '0;
        endcase
    end

    // Clamped configuration.
    always_comb
    begin
        sb_eff = (int'(set_bits_reg) > SET_BITS_MAX) ? SET_BITS_W'(SET_BITS_MAX)
                                                     : set_bits_reg;
        if (ways_used_reg == '0)
        begin
            nways = NW_W'(1);
        end
        else if (int'(ways_used_reg) > WAYS)
        begin
            nways = NW_W'(WAYS);
        end
        else
        begin
            nways = NW_W'(ways_used_reg);
        end
    end

    // Address split into set index and tag.
    assign addr_shifted = address >> offset_bits_reg;
    assign set_mask     = ~({SET_W{1'b1}} << sb_eff);
    assign set_idx      = addr_shifted[SET_W-1:0] & set_mask;
    assign tag_shift    = SHIFT_W'(offset_bits_reg) + SHIFT_W'(sb_eff);

    // Handshakes.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign res_fire  = ((state_reg == ST_RESOLVE) || (state_reg == ST_SECOND))
                       && (!out_valid_reg || !out_stall);

    // Set memory.
    salc_set_mem #(
        .SET_W (SET_W),
        .NSETS (NSETS),
        .ROW_W (ROW_W)
    ) u_set_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (set_idx),
        .wr_en   (res_fire),
        .wr_addr (set_reg),
        .wr_data (row_new),
        .rd_data (mem_rd_data)
    );

    // The second access of a modify works on the row just written.
    assign row_cur = (state_reg == ST_SECOND) ? fwd_row_reg : mem_rd_data;

    salc_way_logic #(
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS),
        .RANK_W    (RANK_W),
        .NW_W      (NW_W),
        .ROW_W     (ROW_W)
    ) u_way_logic (
        .row_in  (row_cur),
        .tag     (tag_reg),
        .nways   (nways),
        .row_out (row_new),
        .status  (status)
    );

    // Next-state logic for control, tallies and the result register.
    always_comb
    begin
        state_next       = state_reg;
        set_bits_next    = set_bits_reg;
        ways_used_next   = ways_used_reg;
        offset_bits_next = offset_bits_reg;
        set_next         = set_reg;
        tag_next         = tag_reg;
        mode_next        = mode_reg;
        fwd_row_next     = fwd_row_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        evicts_next      = evicts_reg;
        out_valid_next   = out_valid_reg && out_stall;
        outcome_next     = outcome_reg;
        last_next        = last_reg;
        hits_out_next    = hits_out_reg;
        misses_out_next  = misses_out_reg;
        evicts_out_next  = evicts_out_reg;

        // Register writes.
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SET_BITS:    set_bits_next    = pwdata[SET_BITS_W-1:0];
                REG_WAYS_USED:   ways_used_next   = pwdata[WAYS_USED_W-1:0];
                REG_OFFSET_BITS: offset_bits_next = pwdata[OFFSET_BITS_W-1:0];
                default:         ;
            endcase
        end

        // Capture a new input word.
        if (in_accept)
        begin
            set_next   = set_idx;
            tag_next   = address >> tag_shift;
            mode_next  = mode;
            state_next = ST_RESOLVE;
        end

        // Resolve an access and load the result word.
        if (res_fire)
        begin
            if (status.hit && (hits_reg != CNT_MAX))
            begin
                hits_next = hits_reg + 1'b1;
            end
            if (status.miss && (misses_reg != CNT_MAX))
            begin
                misses_next = misses_reg + 1'b1;
            end
            if (status.evict && (evicts_reg != CNT_MAX))
            begin
                evicts_next = evicts_reg + 1'b1;
            end
            fwd_row_next    = row_new;
            out_valid_next  = 1'b1;
            outcome_next    = status.outcome;
            last_next       = (state_reg == ST_SECOND) || !mode_reg;
            hits_out_next   = hits_next;
            misses_out_next = misses_next;
            evicts_out_next = evicts_next;
            state_next      = ((state_reg == ST_RESOLVE) && mode_reg) ? ST_SECOND : ST_IDLE;
        end
    end

    // State, configuration, tallies and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            set_bits_reg    <= '0;
            ways_used_reg   <= WAYS_USED_W'(1);
            offset_bits_reg <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evicts_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            set_bits_reg    <= set_bits_next;
            ways_used_reg   <= ways_used_next;
            offset_bits_reg <= offset_bits_next;
            hits_reg        <= hits_next;
            misses_reg      <= misses_next;
            evicts_reg      <= evicts_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        set_reg        <= set_next;
        tag_reg        <= tag_next;
        mode_reg       <= mode_next;
        fwd_row_reg    <= fwd_row_next;
        outcome_reg    <= outcome_next;
        last_reg       <= last_next;
        hits_out_reg   <= hits_out_next;
        misses_out_reg <= misses_out_next;
        evicts_out_reg <= evicts_out_next;
    end

    // Result word outputs.
    assign out_valid       = out_valid_reg;
    assign outcome         = outcome_reg;
    assign last            = last_reg;
    assign hits_total      = hits_out_reg;
    assign misses_total    = misses_out_reg;
    assign evictions_total = evicts_out_reg;

    // Checks on the sequencing and the tallies.
    `SALC_ASSERT_NEXT(a_hits_monotonic, 1'b1, hits_reg >= $past(hits_reg), "hit tally went down")
    `SALC_ASSERT_NEXT(a_first_then_second, res_fire && !last_next, state_reg == ST_SECOND, "modify second access missing")
    `SALC_ASSERT_SAME(a_second_is_modify, state_reg == ST_SECOND, mode_reg, "second access without modify")
    `SALC_ASSERT_NEXT(a_miss_counted, res_fire && status.miss, (misses_reg == $past(misses_reg) + 1'b1) || ($past(misses_reg) == CNT_MAX), "miss not counted")

endmodule

/* src/salc_set_mem.sv */
// ------------------------------------------------------------------------
// Set-associative LRU cache simulator: set memory
// One row per set holding the valid bits, recency ranks and tags of all
// ways. Synchronous, registered read. A row that was never
// written since reset reads as all zero, tracked by one flop per row.
// ------------------------------------------------------------------------
module salc_set_mem
    import salc_pkg::*;
#(
    parameter int SET_W = 8,
    parameter int NSETS = 256,
    parameter int ROW_W = 416
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  logic [ROW_W-1:0] wr_data,
    output logic [ROW_W-1:0] rd_data
);

    logic [ROW_W-1:0] mem [NSETS];
    logic [ROW_W-1:0] rd_data_reg;
    logic [NSETS-1:0] row_init_reg;
    logic             rd_init_reg;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Per-row written flags; reset makes every row read as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg <= '0;
            rd_init_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_init_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_init_reg <= row_init_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_init_reg ? rd_data_reg : '0;

endmodule

/* src/salc_way_logic.sv */
// ------------------------------------------------------------------------
// Set-associative LRU cache simulator: way logic
// Resolves one access against a set row: hit search, first free way,
// LRU victim choice and the rank update, giving the row to write back.
// ------------------------------------------------------------------------
module salc_way_logic
    import salc_pkg::*;
#(
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 48,
    parameter int RANK_W    = 3,
    parameter int NW_W      = 4,
    parameter int ROW_W     = 416
)
(
    input  logic [ROW_W-1:0]     row_in,
    input  logic [ADDR_BITS-1:0] tag,
    input  logic [NW_W-1:0]      nways,
    output logic [ROW_W-1:0]     row_out,
    output access_status_t       status
);

    localparam int RANK_LO = WAYS;
    localparam int TAG_LO  = WAYS + WAYS * RANK_W;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(WAYS - 1);

    logic [WAYS-1:0]      valid;
    logic [RANK_W-1:0]    rank [WAYS];
    logic [ADDR_BITS-1:0] tags [WAYS];
    logic [WAYS-1:0]      in_use;

    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              have_free;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  victim;
    logic [RANK_W-1:0] victim_rank;
    logic [WAY_W-1:0]  sel_way;
    logic [RANK_W-1:0] old_rank;
    logic              touch_all;

    // Unpack the row and mark the ways in use.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            valid[i]  = row_in[i];
            rank[i]   = row_in[RANK_LO + i * RANK_W +: RANK_W];
            tags[i]   = row_in[TAG_LO + i * ADDR_BITS +: ADDR_BITS];
            in_use[i] = (NW_W'(i) < nways);
        end
    end

    // Hit search and first free way; the lowest index wins.
    always_comb
    begin
        hit       = 1'b0;
        hit_way   = '0;
        have_free = 1'b0;
        free_way  = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (in_use[i] && valid[i] && (tags[i] == tag))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (in_use[i] && !valid[i])
            begin
                have_free = 1'b1;
                free_way  = WAY_W'(i);
            end
        end
    end

    // Victim: highest rank among ways in use, lowest index on a tie.
    always_comb
    begin
        victim      = '0;
        victim_rank = rank[0];
        for (int i = 1; i < WAYS; i++)
        begin
            if (in_use[i] && (rank[i] > victim_rank))
            begin
                victim      = WAY_W'(i);
                victim_rank = rank[i];
            end
        end
    end

    // Pick the touched way and its old rank; a filled way counts as oldest.
    always_comb
    begin
        priority if (hit)
        begin
            sel_way   = hit_way;
            old_rank  = rank[hit_way];
            touch_all = 1'b0;
        end
        else if (have_free)
        begin
            sel_way   = free_way;
            old_rank  = '0;
            touch_all = 1'b1;
        end
        else
        begin
            sel_way   = victim;
            old_rank  = victim_rank;
            touch_all = 1'b0;
        end
    end

    // Build the updated row: age the younger ways, make the touched way newest.
    always_comb
    begin
        row_out = row_in;
        for (int i = 0; i < WAYS; i++)
        begin
            if (WAY_W'(i) == sel_way)
            begin
                row_out[i]                                 = 1'b1;
                row_out[RANK_LO + i * RANK_W +: RANK_W]    = '0;
                row_out[TAG_LO + i * ADDR_BITS +: ADDR_BITS] = tag;
            end
            else if (in_use[i] && valid[i] && (touch_all || (rank[i] < old_rank))
                     && (rank[i] != RANK_TOP))
            begin
                row_out[RANK_LO + i * RANK_W +: RANK_W] = rank[i] + 1'b1;
            end
        end
    end

    // Outcome of the access.
    always_comb
    begin
        status.hit   = hit;
        status.miss  = !hit;
        status.evict = !hit && !have_free;
        priority if (hit)
        begin
            status.outcome = OUTCOME_HIT;
        end
        else if (have_free)
        begin
            status.outcome = OUTCOME_FILL;
        end
        else
        begin
            status.outcome = OUTCOME_EVICT;
        end
    end

endmodule
